>>> rtl/core/sit_pkg.sv
// ============================================================================
// sit_pkg
// Shared types and constants of the segment intersection test unit.
// ============================================================================
package sit_pkg;

    localparam int COORD_BITS_DEF     = 24;
    localparam int FRAC_BITS_DEF      = 8;
    localparam int QUOT_FRAC_BITS_DEF = 16;

    localparam int              TOL_BITS  = 16;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd1;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        CODE_EXTENT      = 3'd0,
        CODE_PAR_OFFSET  = 3'd1,
        CODE_COL_OVERLAP = 3'd2,
        CODE_COL_APART   = 3'd3,
        CODE_CROSS       = 3'd4,
        CODE_MISS        = 3'd5,
        CODE_DEGEN       = 3'd6
    } t_code;

    // Classification that travels from the front end to the back end
    typedef struct packed {
        logic  done;   // result already settled in the front end
        logic  hit;
        t_code code;
        logic  sneg;   // sign of the s quotient
        logic  tneg;   // sign of the t quotient
    } t_ctrl;

endpackage

>>> rtl/core/sit_in_if.sv
// ============================================================================
// sit_in_if
// Segment pair channel: valid/ready handshake with both segments' end points.
// ============================================================================
interface sit_in_if #(
    parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] x_x;
    logic signed [COORD_BITS-1:0] x_y;
    logic signed [COORD_BITS-1:0] y_x;
    logic signed [COORD_BITS-1:0] y_y;

    modport source (
        output valid, a_x, a_y, b_x, b_y, x_x, x_y, y_x, y_y,
        input  ready
    );
    modport sink (
        input  valid, a_x, a_y, b_x, b_y, x_x, x_y, y_x, y_y,
        output ready
    );
endinterface

>>> rtl/core/sit_out_if.sv
// ============================================================================
// sit_out_if
// Result channel: valid/ready handshake with hit flag and deciding case.
// ============================================================================
interface sit_out_if;
    logic       valid;
    logic       ready;
    logic       hit;
    logic [2:0] decided_by;

    modport source (
        output valid, hit, decided_by,
        input  ready
    );
    modport sink (
        input  valid, hit, decided_by,
        output ready
    );
endinterface

>>> rtl/core/segment_intersection_test_unit.sv
// ============================================================================
// segment_intersection_test_unit
// Decides if two 2D fixed-point segments meet, one pair per cycle unless stalled.
// ============================================================================
// Pipeline: 4 front stages, the queue, then QUOT_FRAC_BITS + 5 back stages.
// Throughput: one beat per cycle while the queue has room; the divider stages
//   give one quotient bit each.
// A 4-entry queue lets the front end keep taking beats while the output stalls.
// Reset (synchronous, active low) empties the pipeline and queue and sets the
//   tolerance register to 1.
module segment_intersection_test_unit #(
    parameter int COORD_BITS     = sit_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS      = sit_pkg::FRAC_BITS_DEF,
    parameter int QUOT_FRAC_BITS = sit_pkg::QUOT_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sit_pkg::TOL_BITS-1:0]  i_cfg_wdata,
    sit_in_if.sink                        i_seg,
    sit_out_if.source                     o_res
);
    localparam int D   = COORD_BITS + 1;
    localparam int P   = 2 * COORD_BITS + 2;
    localparam int CTW = $bits(sit_pkg::t_ctrl);
    localparam int QDW = CTW + 3 * P + 6 * D;

    logic [sit_pkg::TOL_BITS-1:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= sit_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    logic                f_valid, f_ready;
    sit_pkg::t_ctrl      f_ctrl;
    logic [P-1:0]        f_den, f_sm, f_tm;
    logic signed [D-1:0] f_dx, f_dy, f_exx, f_exy, f_pax, f_pay;

    sit_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tol   (r_tol),
        .i_seg   (i_seg),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_ctrl  (f_ctrl),
        .o_den   (f_den),
        .o_sm    (f_sm),
        .o_tm    (f_tm),
        .o_dx    (f_dx),
        .o_dy    (f_dy),
        .o_exx   (f_exx),
        .o_exy   (f_exy),
        .o_pax   (f_pax),
        .o_pay   (f_pay)
    );

    logic [QDW-1:0] q_wdata, q_rdata;
    logic           b_valid, b_ready;

    assign q_wdata = {f_ctrl, f_den, f_sm, f_tm, f_dx, f_dy, f_exx, f_exy, f_pax, f_pay};

    sit_queue #(
        .WIDTH (QDW),
        .DEPTH (sit_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (q_wdata),
        .o_valid (b_valid),
        .i_ready (b_ready),
        .o_data  (q_rdata)
    );

    sit_pkg::t_ctrl      b_ctrl;
    logic [P-1:0]        b_den, b_sm, b_tm;
    logic signed [D-1:0] b_dx, b_dy, b_exx, b_exy, b_pax, b_pay;

    assign {b_ctrl, b_den, b_sm, b_tm, b_dx, b_dy, b_exx, b_exy, b_pax, b_pay} = q_rdata;

    sit_back #(
        .COORD_BITS     (COORD_BITS),
        .QUOT_FRAC_BITS (QUOT_FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tol   (r_tol),
        .i_valid (b_valid),
        .o_ready (b_ready),
        .i_ctrl  (b_ctrl),
        .i_den   (b_den),
        .i_sm    (b_sm),
        .i_tm    (b_tm),
        .i_dx    (b_dx),
        .i_dy    (b_dy),
        .i_exx   (b_exx),
        .i_exy   (b_exy),
        .i_pax   (b_pax),
        .i_pay   (b_pay),
        .o_res   (o_res)
    );

endmodule

>>> rtl/core/sit_front.sv
// ============================================================================
// sit_front
// Four-stage front end: extent reject, cross products, parallel, collinear
// and degenerate classification. Hands quotient jobs and settled results on.
// ============================================================================
module sit_front #(
    parameter  int COORD_BITS = sit_pkg::COORD_BITS_DEF,
    parameter  int FRAC_BITS  = sit_pkg::FRAC_BITS_DEF,
    localparam int D          = COORD_BITS + 1,
    localparam int P          = 2 * COORD_BITS + 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [sit_pkg::TOL_BITS-1:0]  i_tol,
    sit_in_if.sink                        i_seg,
    output logic                          o_valid,
    input  logic                          i_ready,
    output sit_pkg::t_ctrl                o_ctrl,
    output logic [P-1:0]                  o_den,
    output logic [P-1:0]                  o_sm,
    output logic [P-1:0]                  o_tm,
    output logic signed [D-1:0]           o_dx,
    output logic signed [D-1:0]           o_dy,
    output logic signed [D-1:0]           o_exx,
    output logic signed [D-1:0]           o_exy,
    output logic signed [D-1:0]           o_pax,
    output logic signed [D-1:0]           o_pay
);
    localparam int T  = sit_pkg::TOL_BITS;
    localparam int EW = ((COORD_BITS > T) ? COORD_BITS : T) + 2;
    localparam int ED = D + T + 1;
    localparam int EM = D + T;
    localparam int CW = P + T + FRAC_BITS;

    function automatic logic apart(input logic signed [EW-1:0] p, q, u, v, e);
        logic signed [EW-1:0] pl, ql, ph, qh;
        pl = p - e;
        ql = q - e;
        ph = p + e;
        qh = q + e;
        return (u < pl && u < ql && v < pl && v < ql) ||
               (u > ph && u > qh && v > ph && v > qh);
    endfunction

    function automatic logic signed [D-1:0] diff(input logic signed [COORD_BITS-1:0] a, b);
        return D'(a) - D'(b);
    endfunction

    logic f_en;
    assign f_en        = !o_valid || i_ready;
    assign i_seg.ready = f_en;

    // ---------------- stage 1: differences and extent test ----------------
    logic signed [EW-1:0] c_ax, c_ay, c_bx, c_by, c_xx, c_xy, c_yx, c_yy, c_e;
    logic                 c_ext;

    assign c_ax  = EW'(i_seg.a_x);
    assign c_ay  = EW'(i_seg.a_y);
    assign c_bx  = EW'(i_seg.b_x);
    assign c_by  = EW'(i_seg.b_y);
    assign c_xx  = EW'(i_seg.x_x);
    assign c_xy  = EW'(i_seg.x_y);
    assign c_yx  = EW'(i_seg.y_x);
    assign c_yy  = EW'(i_seg.y_y);
    assign c_e   = EW'($signed({1'b0, i_tol}));
    assign c_ext = apart(c_ax, c_bx, c_xx, c_yx, c_e) || apart(c_ay, c_by, c_xy, c_yy, c_e);

    logic                r1_v, r1_ext;
    logic signed [D-1:0] r1_dx, r1_dy, r1_exx, r1_exy, r1_pax, r1_pay, r1_nyx, r1_nyy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (f_en) begin
            r1_v <= i_seg.valid;
        end
        if (f_en) begin
            r1_ext <= c_ext;
            r1_dx  <= diff(i_seg.b_x, i_seg.a_x);
            r1_dy  <= diff(i_seg.b_y, i_seg.a_y);
            r1_exx <= diff(i_seg.x_x, i_seg.y_x);
            r1_exy <= diff(i_seg.x_y, i_seg.y_y);
            r1_pax <= diff(i_seg.a_x, i_seg.x_x);
            r1_pay <= diff(i_seg.a_y, i_seg.x_y);
            r1_nyx <= diff(i_seg.y_x, i_seg.a_x);
            r1_nyy <= diff(i_seg.y_y, i_seg.a_y);
        end
    end

    // ---------------- stage 2: products, collinear axis choice ----------------
    logic signed [D-1:0] c_adx, c_d, c_nx, c_ny;
    logic                c_xb;

    assign c_adx = (r1_dx < 0) ? -r1_dx : r1_dx;
    assign c_xb  = c_adx > $signed({1'b0, i_tol});
    assign c_d   = c_xb ? r1_dx : r1_dy;
    assign c_nx  = c_xb ? -r1_pax : -r1_pay;
    assign c_ny  = c_xb ? r1_nyx : r1_nyy;

    logic                r2_v, r2_ext, r2_xb, r2_deg;
    logic signed [P-1:0] r2_p1, r2_p2, r2_p3, r2_p4, r2_p5, r2_p6;
    logic signed [ED-1:0] r2_edx, r2_edy;
    logic signed [D-1:0] r2_d, r2_nx, r2_ny;
    logic signed [D-1:0] r2_dx, r2_dy, r2_exx, r2_exy, r2_pax, r2_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (f_en) begin
            r2_v <= r1_v;
        end
        if (f_en) begin
            r2_ext <= r1_ext;
            r2_xb  <= c_xb;
            r2_deg <= !c_xb && (r1_dy == '0);
            r2_p1  <= r1_dx * r1_exy;
            r2_p2  <= r1_dy * r1_exx;
            r2_p3  <= r1_exx * r1_pay;
            r2_p4  <= r1_exy * r1_pax;
            r2_p5  <= r1_pax * r1_dy;
            r2_p6  <= r1_pay * r1_dx;
            r2_edx <= r1_dx * $signed({1'b0, i_tol});
            r2_edy <= r1_dy * $signed({1'b0, i_tol});
            r2_d   <= c_d;
            r2_nx  <= c_nx;
            r2_ny  <= c_ny;
            r2_dx  <= r1_dx;
            r2_dy  <= r1_dy;
            r2_exx <= r1_exx;
            r2_exy <= r1_exy;
            r2_pax <= r1_pax;
            r2_pay <= r1_pay;
        end
    end

    // ---------------- stage 3: cross sums, sign normalize ----------------
    logic signed [ED-1:0] c_ed;
    logic                 c_dneg;

    assign c_ed   = r2_xb ? r2_edx : r2_edy;
    assign c_dneg = r2_d < 0;

    logic                r3_v, r3_ext, r3_deg;
    logic signed [P-1:0] r3_den, r3_ns, r3_nt;
    logic [EM-1:0]       r3_emd;
    logic signed [D-1:0] r3_dn, r3_nxn, r3_nyn;
    logic signed [D-1:0] r3_dx, r3_dy, r3_exx, r3_exy, r3_pax, r3_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (f_en) begin
            r3_v <= r2_v;
        end
        if (f_en) begin
            r3_ext <= r2_ext;
            r3_deg <= r2_deg;
            r3_den <= r2_p1 - r2_p2;
            r3_ns  <= r2_p3 - r2_p4;
            r3_nt  <= r2_p5 - r2_p6;
            r3_emd <= EM'((c_ed < 0) ? -c_ed : c_ed);
            r3_dn  <= c_dneg ? -r2_d : r2_d;
            r3_nxn <= c_dneg ? -r2_nx : r2_nx;
            r3_nyn <= c_dneg ? -r2_ny : r2_ny;
            r3_dx  <= r2_dx;
            r3_dy  <= r2_dy;
            r3_exx <= r2_exx;
            r3_exy <= r2_exy;
            r3_pax <= r2_pax;
            r3_pay <= r2_pay;
        end
    end

    // ---------------- stage 4: classify ----------------
    logic [P-1:0]   c_aden, c_ans, c_ant;
    logic           c_par, c_offbad, c_inrange;
    sit_pkg::t_ctrl c_ctrl;

    assign c_aden = P'((r3_den < 0) ? -r3_den : r3_den);
    assign c_ans  = P'((r3_ns < 0) ? -r3_ns : r3_ns);
    assign c_ant  = P'((r3_nt < 0) ? -r3_nt : r3_nt);
    assign c_par  = (r3_den == '0) || (CW'(c_aden) < (CW'(i_tol) << FRAC_BITS));
    // offset of X from AB equals the t numerator up to sign
    assign c_offbad  = CW'(c_ant) > CW'(r3_emd);
    assign c_inrange = (r3_nxn >= 0 && r3_nxn <= r3_dn) || (r3_nyn >= 0 && r3_nyn <= r3_dn) ||
                       (r3_nxn < 0 && r3_nyn > r3_dn) || (r3_nyn < 0 && r3_nxn > r3_dn);

    always_comb begin
        c_ctrl      = '0;
        c_ctrl.sneg = (r3_ns < 0) ^ (r3_den < 0);
        c_ctrl.tneg = (r3_nt < 0) ^ (r3_den < 0);
        c_ctrl.code = sit_pkg::CODE_MISS;
        priority if (r3_ext) begin
            c_ctrl.done = 1'b1;
            c_ctrl.code = sit_pkg::CODE_EXTENT;
        end else if (c_par && r3_deg) begin
            c_ctrl.done = 1'b1;
            c_ctrl.code = sit_pkg::CODE_DEGEN;
        end else if (c_par && c_offbad) begin
            c_ctrl.done = 1'b1;
            c_ctrl.code = sit_pkg::CODE_PAR_OFFSET;
        end else if (c_par && c_inrange) begin
            c_ctrl.done = 1'b1;
            c_ctrl.hit  = 1'b1;
            c_ctrl.code = sit_pkg::CODE_COL_OVERLAP;
        end else if (c_par) begin
            c_ctrl.done = 1'b1;
            c_ctrl.code = sit_pkg::CODE_COL_APART;
        end else begin
            c_ctrl.done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (f_en) begin
            o_valid <= r3_v;
        end
        if (f_en) begin
            o_ctrl <= c_ctrl;
            o_den  <= c_aden;
            o_sm   <= c_ans;
            o_tm   <= c_ant;
            o_dx   <= r3_dx;
            o_dy   <= r3_dy;
            o_exx  <= r3_exx;
            o_exy  <= r3_exy;
            o_pax  <= r3_pax;
            o_pay  <= r3_pay;
        end
    end

    a_ext_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(f_en) && $past(r3_ext)) |-> (o_ctrl.done &&
            o_ctrl.code == sit_pkg::CODE_EXTENT))
        else $error("extent reject not settled in front end");

endmodule

>>> rtl/core/sit_queue.sv
// ============================================================================
// sit_queue
// Small register queue that decouples the front end from the back end.
// ============================================================================
module sit_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sit_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CNTW-1:0]  r_cnt;
    logic             push, pop;

    assign o_ready = r_cnt != CNTW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNTW'(DEPTH))
        else $error("queue count beyond depth");

    a_cnt_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count missed a push");

endmodule

>>> rtl/core/sit_back.sv
// ============================================================================
// sit_back
// Back end: two restoring dividers, one quotient bit per stage, then the
// parametric point match and the result register.
// ============================================================================
module sit_back #(
    parameter  int COORD_BITS     = sit_pkg::COORD_BITS_DEF,
    parameter  int QUOT_FRAC_BITS = sit_pkg::QUOT_FRAC_BITS_DEF,
    localparam int D              = COORD_BITS + 1,
    localparam int P              = 2 * COORD_BITS + 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [sit_pkg::TOL_BITS-1:0]  i_tol,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  sit_pkg::t_ctrl                i_ctrl,
    input  logic [P-1:0]                  i_den,
    input  logic [P-1:0]                  i_sm,
    input  logic [P-1:0]                  i_tm,
    input  logic signed [D-1:0]           i_dx,
    input  logic signed [D-1:0]           i_dy,
    input  logic signed [D-1:0]           i_exx,
    input  logic signed [D-1:0]           i_exy,
    input  logic signed [D-1:0]           i_pax,
    input  logic signed [D-1:0]           i_pay,
    sit_out_if.source                     o_res
);
    localparam int QF = QUOT_FRAC_BITS;
    localparam int QW = QF + 2;
    localparam int SW = QF + 3;
    localparam int MW = D + SW;
    localparam int XW = MW + 2;
    localparam int CW = XW + sit_pkg::TOL_BITS;

    typedef struct packed {
        sit_pkg::t_ctrl      ctrl;
        logic signed [D-1:0] dx, dy, exx, exy, pax, pay;
        logic [P-1:0]        den, rs, rt;
        logic [QF:0]         qs, qt;
        logic                sats, satt;
    } t_dstage;

    function automatic logic [P:0] dstep(input logic [P-1:0] r, den);
        logic [P-1:0] r2;
        r2 = {r[P-2:0], 1'b0};
        if (r2 >= den) begin
            return {1'b1, r2 - den};
        end
        return {1'b0, r2};
    endfunction

    // advance both quotients by one bit
    function automatic t_dstage div_stage(input t_dstage p);
        t_dstage    n;
        logic [P:0] ss, st;
        n    = p;
        ss   = dstep(p.rs, p.den);
        st   = dstep(p.rt, p.den);
        n.rs = ss[P-1:0];
        n.rt = st[P-1:0];
        n.qs = {p.qs[QF-1:0], ss[P]};
        n.qt = {p.qt[QF-1:0], st[P]};
        return n;
    endfunction

    logic b_en;
    assign b_en    = !o_res.valid || o_res.ready;
    assign o_ready = b_en;

    // ---------------- divider entry: integer part and saturation ----------------
    t_dstage c_d0;
    logic    c_ips, c_ipt;

    always_comb begin
        c_ips       = i_sm >= i_den;
        c_ipt       = i_tm >= i_den;
        c_d0.ctrl   = i_ctrl;
        c_d0.dx     = i_dx;
        c_d0.dy     = i_dy;
        c_d0.exx    = i_exx;
        c_d0.exy    = i_exy;
        c_d0.pax    = i_pax;
        c_d0.pay    = i_pay;
        c_d0.den    = i_den;
        c_d0.sats   = {1'b0, i_sm} >= {i_den, 1'b0};
        c_d0.satt   = {1'b0, i_tm} >= {i_den, 1'b0};
        c_d0.rs     = c_ips ? i_sm - i_den : i_sm;
        c_d0.rt     = c_ipt ? i_tm - i_den : i_tm;
        c_d0.qs     = (QF + 1)'(c_ips);
        c_d0.qt     = (QF + 1)'(c_ipt);
    end

    t_dstage r_d  [QF + 1];
    logic    r_dv [QF + 1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QF; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (b_en) begin
            r_dv[0] <= i_valid;
            for (int k = 1; k <= QF; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
        if (b_en) begin
            r_d[0] <= c_d0;
            for (int k = 1; k <= QF; k++) begin
                r_d[k] <= div_stage(r_d[k-1]);
            end
        end
    end

    // ---------------- signed quotients and range test ----------------
    logic [QW-1:0] c_qs, c_qt;
    logic          c_fail;

    assign c_qs   = r_d[QF].sats ? (QW'(2) << QF) : QW'(r_d[QF].qs);
    assign c_qt   = r_d[QF].satt ? (QW'(2) << QF) : QW'(r_d[QF].qt);
    assign c_fail = (r_d[QF].ctrl.sneg && c_qs != '0) || (c_qs > (QW'(1) << QF)) ||
                    (r_d[QF].ctrl.tneg && c_qt != '0) || (c_qt > (QW'(1) << QF));

    logic                 r_xv, r_xfail;
    sit_pkg::t_ctrl       r_xctrl;
    logic signed [SW-1:0] r_s, r_t;
    logic signed [D-1:0]  r_xdx, r_xdy, r_xexx, r_xexy, r_xpax, r_xpay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xv <= 1'b0;
        end else if (b_en) begin
            r_xv <= r_dv[QF];
        end
        if (b_en) begin
            r_xfail <= c_fail;
            r_xctrl <= r_d[QF].ctrl;
            r_s     <= r_d[QF].ctrl.sneg ? -$signed(SW'(c_qs)) : $signed(SW'(c_qs));
            r_t     <= r_d[QF].ctrl.tneg ? -$signed(SW'(c_qt)) : $signed(SW'(c_qt));
            r_xdx   <= r_d[QF].dx;
            r_xdy   <= r_d[QF].dy;
            r_xexx  <= r_d[QF].exx;
            r_xexy  <= r_d[QF].exy;
            r_xpax  <= r_d[QF].pax;
            r_xpay  <= r_d[QF].pay;
        end
    end

    // ---------------- products ----------------
    logic                 r_mv, r_mfail;
    sit_pkg::t_ctrl       r_mctrl;
    logic signed [MW-1:0] r_sdx, r_sdy, r_texx, r_texy;
    logic signed [D-1:0]  r_mpax, r_mpay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (b_en) begin
            r_mv <= r_xv;
        end
        if (b_en) begin
            r_mfail <= r_xfail;
            r_mctrl <= r_xctrl;
            r_sdx   <= r_s * r_xdx;
            r_sdy   <= r_s * r_xdy;
            r_texx  <= r_t * r_xexx;
            r_texy  <= r_t * r_xexy;
            r_mpax  <= r_xpax;
            r_mpay  <= r_xpay;
        end
    end

    // ---------------- point difference ----------------
    logic                 r_sv, r_sfail;
    sit_pkg::t_ctrl       r_sctrl;
    logic signed [XW-1:0] r_ex, r_ey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else if (b_en) begin
            r_sv <= r_mv;
        end
        if (b_en) begin
            r_sfail <= r_mfail;
            r_sctrl <= r_mctrl;
            r_ex    <= (XW'(r_mpax) <<< QF) + XW'(r_sdx) + XW'(r_texx);
            r_ey    <= (XW'(r_mpay) <<< QF) + XW'(r_sdy) + XW'(r_texy);
        end
    end

    // ---------------- result ----------------
    logic [XW-1:0] c_aex, c_aey;
    logic          c_match;
    logic          r_hit;
    sit_pkg::t_code r_code;

    assign c_aex   = XW'((r_ex < 0) ? -r_ex : r_ex);
    assign c_aey   = XW'((r_ey < 0) ? -r_ey : r_ey);
    assign c_match = (CW'(c_aex) < (CW'(i_tol) << QF)) && (CW'(c_aey) < (CW'(i_tol) << QF));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res.valid <= 1'b0;
        end else if (b_en) begin
            o_res.valid <= r_sv;
        end
        if (b_en) begin
            priority if (r_sctrl.done) begin
                r_hit  <= r_sctrl.hit;
                r_code <= r_sctrl.code;
            end else if (!r_sfail && c_match) begin
                r_hit  <= 1'b1;
                r_code <= sit_pkg::CODE_CROSS;
            end else begin
                r_hit  <= 1'b0;
                r_code <= sit_pkg::CODE_MISS;
            end
        end
    end

    assign o_res.hit        = r_hit;
    assign o_res.decided_by = r_code;

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ctrl.done) |-> (i_den != '0))
        else $error("quotient job with zero denominator");

    a_hit_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (r_hit == (r_code == sit_pkg::CODE_CROSS ||
                                   r_code == sit_pkg::CODE_COL_OVERLAP)))
        else $error("hit flag disagrees with deciding case");

endmodule

>>> verif/segment_intersection_test_unit_chk.sv
// ----------------------------------------------------------------------------
// segment_intersection_test_unit_chk
// Watches both channels, predicts hit and deciding case for every accepted
// segment pair and compares them in order with the result beats.
// ----------------------------------------------------------------------------
module segment_intersection_test_unit_chk (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sit_pkg::TOL_BITS-1:0] i_cfg_wdata,
    sit_in_if.sink                       i_seg,
    sit_out_if.sink                      i_res,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QF = sit_pkg::QUOT_FRAC_BITS_DEF;
    localparam int FB = sit_pkg::FRAC_BITS_DEF;

    typedef struct packed {
        logic           hit;
        sit_pkg::t_code code;
    } t_verdict;

    t_verdict                     verdict_q[$];
    logic [sit_pkg::TOL_BITS-1:0] tol_shadow;
    int                           fail_cnt;

    assign o_fail_count = fail_cnt;
    assign o_pending    = verdict_q.size();

    function automatic longint absv(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic bit extents_apart(longint p, longint q, longint u, longint v,
                                         longint e);
        bit lo, hi;
        lo = u < p - e && u < q - e && v < p - e && v < q - e;
        hi = u > p + e && u > q + e && v > p + e && v > q + e;
        return lo || hi;
    endfunction

    function automatic longint param_quot(longint num, longint den);
        longint m, ip, r, q;
        m  = absv(num);
        ip = m / den;
        r  = m % den;
        if (ip >= 2) begin
            q = longint'(2) << QF;
        end else begin
            q = ip;
            for (int i = 0; i < QF; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= den) begin
                    r = r - den;
                    q = q | 1;
                end
            end
        end
        return num < 0 ? -q : q;
    endfunction

    function automatic t_verdict judge_pair(longint ax, longint ay, longint bx,
                                            longint by, longint xx, longint xy,
                                            longint yx, longint yy, longint e);
        longint one, dx, dy, den, ns, nt, s, t, ex, ey, d, nx, ny, off;
        one = longint'(1) << QF;
        dx  = bx - ax;
        dy  = by - ay;
        if (extents_apart(ax, bx, xx, yx, e) || extents_apart(ay, by, xy, yy, e))
            return '{1'b0, sit_pkg::CODE_EXTENT};
        den = dx * (xy - yy) - dy * (xx - yx);
        if (den == 0 || absv(den) < (e << FB)) begin
            if (absv(dx) > e) begin
                d = dx; nx = xx - ax; ny = yx - ax;
                off = (ay - xy) * dx + nx * dy;
            end else begin
                if (dy == 0) return '{1'b0, sit_pkg::CODE_DEGEN};
                d = dy; nx = xy - ay; ny = yy - ay;
                off = (ax - xx) * dy + nx * dx;
            end
            if (absv(off) > e * absv(d)) return '{1'b0, sit_pkg::CODE_PAR_OFFSET};
            if (d < 0) begin
                d = -d; nx = -nx; ny = -ny;
            end
            if ((nx >= 0 && nx <= d) || (ny >= 0 && ny <= d))
                return '{1'b1, sit_pkg::CODE_COL_OVERLAP};
            if ((nx < 0 && ny > d) || (ny < 0 && nx > d))
                return '{1'b1, sit_pkg::CODE_COL_OVERLAP};
            return '{1'b0, sit_pkg::CODE_COL_APART};
        end
        ns = (xx - yx) * (ay - xy) - (xy - yy) * (ax - xx);
        nt = (ax - xx) * dy - (ay - xy) * dx;
        if (den < 0) begin
            den = -den; ns = -ns; nt = -nt;
        end
        s = param_quot(ns, den);
        t = param_quot(nt, den);
        if (s < 0 || s > one || t < 0 || t > one) return '{1'b0, sit_pkg::CODE_MISS};
        ex = (ax * one + s * dx) - (xx * one + t * (yx - xx));
        ey = (ay * one + s * dy) - (xy * one + t * (yy - xy));
        if (absv(ex) < e * one && absv(ey) < e * one) return '{1'b1, sit_pkg::CODE_CROSS};
        return '{1'b0, sit_pkg::CODE_MISS};
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            tol_shadow <= sit_pkg::TOL_RESET;
            verdict_q.delete();
            fail_cnt <= 0;
        end else begin
            if (i_seg.valid && i_seg.ready)
                verdict_q.push_back(judge_pair(i_seg.a_x, i_seg.a_y, i_seg.b_x,
                    i_seg.b_y, i_seg.x_x, i_seg.x_y, i_seg.y_x, i_seg.y_y,
                    longint'(tol_shadow)));
            if (i_res.valid && i_res.ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result beat hit=%0b code=%0d", $time,
                             i_res.hit, i_res.decided_by);
                    fail_cnt <= fail_cnt + 1;
                end else begin
                    want = verdict_q.pop_front();
                    if (want.hit !== i_res.hit || want.code !== i_res.decided_by) begin
                        $display("%0t: mismatch expected hit=%0b code=%0d, actual hit=%0b code=%0d",
                                 $time, want.hit, want.code, i_res.hit, i_res.decided_by);
                        fail_cnt <= fail_cnt + 1;
                    end
                end
            end
            if (i_cfg_we) tol_shadow <= i_cfg_wdata;
        end
    end
endmodule

>>> verif/segment_intersection_test_unit_tb.sv
// ----------------------------------------------------------------------------
// segment_intersection_test_unit_tb
// Drives directed and random segment pairs under several tolerance settings,
// with random idling and back pressure; the checker judges every result.
// ----------------------------------------------------------------------------
module segment_intersection_test_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 10 + sit_pkg::QUOT_FRAC_BITS_DEF;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         cfg_we;
    logic [sit_pkg::TOL_BITS-1:0] cfg_wdata;
    int                           fail_count;
    int                           pending;
    bit                           calm;       // no idling on either side
    int                           hold_left;  // receiver long hold-off cycles
    bit                           stim_done;

    sit_in_if  seg_if ();
    sit_out_if res_if ();

    segment_intersection_test_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_seg       (seg_if.sink),
        .o_res       (res_if.source)
    );

    segment_intersection_test_unit_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_seg        (seg_if.sink),
        .i_res        (res_if.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

    // receiver: random stalls, plus a counted long hold-off
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left    = hold_left - 1;
                res_if.ready = 1'b0;
            end else begin
                res_if.ready = calm || ($urandom_range(99) >= 27);
            end
        end
    end

    function automatic logic [23:0] rand_coord(int mode);
        case (mode)
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(4000)) - 2000);
            default: return 24'($signed($urandom_range(200)) - 100);
        endcase
    endfunction

    task automatic send_pair(int ax, int ay, int bx, int by, int xx, int xy,
                             int yx, int yy);
        while (!calm && $urandom_range(99) < 27) begin
            seg_if.valid = 1'b0;
            @(negedge i_clk);
        end
        seg_if.valid = 1'b1;
        seg_if.a_x = 24'(ax); seg_if.a_y = 24'(ay); seg_if.b_x = 24'(bx);
        seg_if.b_y = 24'(by); seg_if.x_x = 24'(xx); seg_if.x_y = 24'(xy);
        seg_if.y_x = 24'(yx); seg_if.y_y = 24'(yy);
        do @(posedge i_clk); while (!seg_if.ready);
        @(negedge i_clk);
        seg_if.valid = 1'b0;
    endtask

    task automatic drain_and_set(logic [sit_pkg::TOL_BITS-1:0] tol);
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
        cfg_wdata = tol;
        cfg_we    = 1'b1;
        @(negedge i_clk);
        cfg_we    = 1'b0;
    endtask

    task automatic random_pair();
        int                 kind, mode;
        logic signed [23:0] ax, ay, bx, by, xx, xy, yx, yy, k;
        kind = $urandom_range(9);
        mode = $urandom_range(2);
        ax = rand_coord(mode); ay = rand_coord(mode);
        bx = rand_coord(mode); by = rand_coord(mode);
        xx = rand_coord(mode); xy = rand_coord(mode);
        yx = rand_coord(mode); yy = rand_coord(mode);
        case (kind)
            0, 1: begin
                // XY along AB: collinear cases
                k  = 24'($urandom_range(6));
                xx = 24'(ax + (bx - ax) * (k - 2) / 2);
                xy = 24'(ay + (by - ay) * (k - 2) / 2);
                k  = 24'($urandom_range(6));
                yx = 24'(ax + (bx - ax) * (k - 2) / 2);
                yy = 24'(ay + (by - ay) * (k - 2) / 2);
            end
            2: begin
                // parallel offset
                k  = 24'($urandom_range(8));
                xx = ax + k; xy = ay - k; yx = bx + k; yy = by - k;
            end
            3: begin
                bx = ax + 24'($urandom_range(2)); by = ay;
            end
            4, 5, 6: begin
                // crossing through a shared midpoint
                xx = (ax + bx) - yx; xy = (ay + by) - yy;
            end
            default: ;
        endcase
        send_pair(int'(ax), int'(ay), int'(bx), int'(by), int'(xx), int'(xy),
                  int'(yx), int'(yy));
    endtask

    localparam int CMAX = 8388607;
    localparam int CMIN = -8388608;

    initial begin
        logic [sit_pkg::TOL_BITS-1:0] tols[6];
        tols = '{16'd1, 16'd0, 16'hFFFF, 16'd16, 16'd3, 16'd300};
        calm = 1'b0; hold_left = 0; stim_done = 1'b0;
        cfg_we = 1'b0; cfg_wdata = '0;
        seg_if.valid = 1'b0;
        seg_if.a_x = '0; seg_if.a_y = '0; seg_if.b_x = '0; seg_if.b_y = '0;
        seg_if.x_x = '0; seg_if.x_y = '0; seg_if.y_x = '0; seg_if.y_y = '0;
        i_rst_n = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: extremes, crossing, collinear, parallel, degenerate
        send_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
        send_pair(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX);
        send_pair(0, 0, 256, 0, 512, 512, 768, 768);
        send_pair(0, 0, 256, 256, 0, 256, 256, 0);
        send_pair(0, 0, 1024, 0, 256, 0, 512, 0);
        send_pair(0, 0, 1024, 0, -256, 0, 2048, 0);
        send_pair(0, 0, 256, 0, 512, 0, 768, 0);
        send_pair(0, 0, 1024, 0, 0, 100, 1024, 100);
        send_pair(0, 0, 0, 1024, 0, 256, 0, 512);
        send_pair(5, 5, 5, 5, 5, 5, 5, 5);
        send_pair(5, 5, 6, 5, 0, 5, 9, 5);
        send_pair(0, 0, 256, 256, 512, 0, 0, 1);
        send_pair(0, 0, 100, 0, 50, -50, 50, 50);
        send_pair(CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX);
        send_pair(CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN);
        send_pair(-100, -100, 100, 100, -100, 100, 100, -100);

        for (int ph = 0; ph < 6; ph++) begin
            drain_and_set(tols[ph]);
            calm = (ph == 2);
            for (int n = 0; n < 190; n++) begin
                if (ph == 3 && n == 20) hold_left = 200;
                if (ph == 4 && n == 100) begin
                    while (pending != 0) @(negedge i_clk);
                end
                random_pair();
            end
        end
        calm = 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
